// ===== rtl/sat_pkg.sv =====
// ----------------------------------------------------------------------------
// Shell argument tokenizer package
// Character codes, status codes, quote modes and the result record.
// ----------------------------------------------------------------------------
package sat_pkg;

   localparam int BUF_LEN_DEFAULT       = 256;
   localparam int MAX_ARGUMENTS_DEFAULT = 16;

   // Characters that steer the splitter
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   // Quote modes
   localparam logic [1:0] QUOTE_NONE   = 2'd0;
   localparam logic [1:0] QUOTE_SINGLE = 2'd1;
   localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

   // End-of-line status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG    = 2'd1;
   localparam logic [1:0] STATUS_TOO_MANY    = 2'd2;
   localparam logic [1:0] STATUS_OPEN_QUOTE  = 2'd3;

   typedef struct packed {
      logic       write_en;
      logic [7:0] write_byte;
      logic [7:0] position;
      logic       arg_start;
      logic [3:0] arg_index;
      logic       done_res;
      logic [1:0] status;
      logic [4:0] arg_count;
   } result_type;

endpackage

// ===== rtl/shell_argument_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// Shell argument tokenizer
// Splits a zero-terminated command line into arguments, one byte per cycle max.
// ----------------------------------------------------------------------------
// The block takes one line byte per req_ transaction; byte 0 ends the line.
// Space and tab separate arguments outside quotes, single quotes are literal,
// double quotes and bare text honor backslash escapes, and a backslash just
// before the end of the line is kept as a literal backslash. Each byte gives
// zero, one or two rsp_ transactions describing argument starts and buffer
// writes (separators write a zero byte); the last transaction of a line has
// rsp_tlast set and carries the argument count or an error status. After a
// too-long or too-many-arguments error the rest of the line is dropped
// silently and the terminating zero re-arms the block.
// Rate: one byte is accepted every cycle while req_tready is high. Each byte is
// decoded combinationally against the line state and its results are pushed
// into a four-entry result queue, which drains one transaction per cycle
// unless stalled; with nothing queued ahead, a byte's first result appears
// on rsp_ the cycle after it is accepted. req_tready stays high while at most
// two results are waiting, leaving room for the two that an end-of-line byte
// after a trailing backslash produces; under a stalled result side input stops
// once three results wait (bytes with no result do not fill the queue).
// ----------------------------------------------------------------------------
module shell_argument_tokenizer_top #(
   parameter int BUF_LEN       = sat_pkg::BUF_LEN_DEFAULT,       // 4 .. 256
   parameter int MAX_ARGUMENTS = sat_pkg::MAX_ARGUMENTS_DEFAULT  // 1 .. 16
) (
   input  logic        clock,
   input  logic        reset,
   // line bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] write_byte, [15:8] position,
                                    // [19:16] arg_index, [21:20] status,
                                    // [26:22] arg_count, [31:27] zero
   output logic [1:0]  rsp_tuser,   // [0] write_en, [1] arg_start
   output logic        rsp_tlast    // done_res: last result of the line
);
   import sat_pkg::*;

   localparam int POS_W = $clog2(BUF_LEN);
   localparam int ARG_W = $clog2(MAX_ARGUMENTS + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(BUF_LEN - 1);
   localparam logic [ARG_W-1:0] ARG_LIMIT = ARG_W'(MAX_ARGUMENTS);

   // result queue geometry
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // ---------------------------------------------------------------------
   // Line state
   // ---------------------------------------------------------------------
   logic [1:0]       quote_mode_ff, quote_mode_in;
   logic             in_word_ff, in_word_in;
   logic             escape_ff, escape_in;
   logic [POS_W-1:0] out_pos_ff, out_pos_in;
   logic [ARG_W-1:0] args_seen_ff, args_seen_in;
   logic             skipping_ff, skipping_in;

   // result queue
   result_type        queue_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic       req_fire;
   logic       rsp_fire;
   logic [7:0] ch;
   logic       is_blank;

   // results of the current byte
   result_type res_a;
   result_type res_b;
   logic [1:0] push_cnt;

   // per-byte scratch
   logic       start;
   logic       wen;
   logic [7:0] wbyte;

   assign ch       = req_tdata;
   assign is_blank = ch inside {CHAR_SPACE, CHAR_TAB};

   // Ready while at least two result slots are free
   assign req_tready = (count_ff <= QCNT_W'(QDEPTH - 2));
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_fire   = rsp_tvalid & rsp_tready;

   // ---------------------------------------------------------------------
   // Byte decode: one pass against the current line state
   // ---------------------------------------------------------------------
   always_comb begin
      quote_mode_in = quote_mode_ff;
      in_word_in    = in_word_ff;
      escape_in     = escape_ff;
      out_pos_in    = out_pos_ff;
      args_seen_in  = args_seen_ff;
      skipping_in   = skipping_ff;
      res_a         = '0;
      res_b         = '0;
      push_cnt      = 2'd0;
      start         = 1'b0;
      wen           = 1'b0;
      wbyte         = 8'h00;

      if (skipping_ff) begin
         // drop everything after an error; the zero byte re-arms
         if (ch == CHAR_NUL) begin
            quote_mode_in = QUOTE_NONE;
            in_word_in    = 1'b0;
            escape_in     = 1'b0;
            out_pos_in    = '0;
            args_seen_in  = '0;
            skipping_in   = 1'b0;
         end
      end else if (ch == CHAR_NUL) begin
         // end of line, with a literal backslash first if one is pending
         if (escape_ff) begin
            res_a.write_en   = 1'b1;
            res_a.write_byte = CHAR_BACKSLASH;
            res_a.position   = 8'(out_pos_ff);
            res_b.done_res   = 1'b1;
            if (quote_mode_ff != QUOTE_NONE) begin
               res_b.status = STATUS_OPEN_QUOTE;
            end else begin
               res_b.write_en  = 1'b1;
               res_b.position  = 8'(out_pos_ff + 1'b1);
               res_b.status    = STATUS_OK;
               res_b.arg_count = 5'(args_seen_ff);
            end
            push_cnt = 2'd2;
         end else begin
            res_a.done_res = 1'b1;
            if (quote_mode_ff != QUOTE_NONE) begin
               res_a.status = STATUS_OPEN_QUOTE;
            end else begin
               res_a.write_en  = 1'b1;
               res_a.position  = 8'(out_pos_ff);
               res_a.status    = STATUS_OK;
               res_a.arg_count = 5'(args_seen_ff);
            end
            push_cnt = 2'd1;
         end
         quote_mode_in = QUOTE_NONE;
         in_word_in    = 1'b0;
         escape_in     = 1'b0;
         out_pos_in    = '0;
         args_seen_in  = '0;
      end else if (escape_ff) begin
         // escaped byte is written as is
         escape_in        = 1'b0;
         res_a.write_en   = 1'b1;
         res_a.write_byte = ch;
         res_a.position   = 8'(out_pos_ff);
         out_pos_in       = out_pos_ff + 1'b1;
         push_cnt         = 2'd1;
      end else if (out_pos_ff >= POS_LIMIT) begin
         res_a.done_res = 1'b1;
         res_a.status   = STATUS_TOO_LONG;
         skipping_in    = 1'b1;
         push_cnt       = 2'd1;
      end else if (!in_word_ff && is_blank) begin
         // separator between words: nothing to report
      end else if (!in_word_ff && (args_seen_ff >= ARG_LIMIT)) begin
         res_a.done_res = 1'b1;
         res_a.status   = STATUS_TOO_MANY;
         skipping_in    = 1'b1;
         push_cnt       = 2'd1;
      end else begin
         if (!in_word_ff) begin
            start        = 1'b1;
            args_seen_in = args_seen_ff + 1'b1;
            in_word_in   = 1'b1;
         end

         if (quote_mode_ff != QUOTE_NONE) begin
            if ((quote_mode_ff == QUOTE_SINGLE && ch == CHAR_SQUOTE) ||
                (quote_mode_ff != QUOTE_SINGLE && ch == CHAR_DQUOTE)) begin
               quote_mode_in = QUOTE_NONE;
            end else if (quote_mode_ff != QUOTE_SINGLE && ch == CHAR_BACKSLASH) begin
               escape_in = 1'b1;
            end else begin
               wen   = 1'b1;
               wbyte = ch;
            end
         end else if (ch == CHAR_SQUOTE) begin
            quote_mode_in = QUOTE_SINGLE;
         end else if (ch == CHAR_DQUOTE) begin
            quote_mode_in = QUOTE_DOUBLE;
         end else if (ch == CHAR_BACKSLASH) begin
            escape_in = 1'b1;
         end else if (is_blank) begin
            // separator closes the word with a zero byte
            wen        = 1'b1;
            wbyte      = 8'h00;
            in_word_in = 1'b0;
         end else begin
            wen   = 1'b1;
            wbyte = ch;
         end

         if (wen) begin
            out_pos_in = out_pos_ff + 1'b1;
         end

         res_a.write_en   = wen;
         res_a.write_byte = wbyte;
         res_a.position   = 8'(out_pos_ff);
         res_a.arg_start  = start;
         res_a.arg_index  = start ? 4'(args_seen_ff) : 4'd0;
         push_cnt         = (start || wen) ? 2'd1 : 2'd0;
      end
   end

   // ---------------------------------------------------------------------
   // Queue pointers
   // ---------------------------------------------------------------------
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(push_cnt);
         count_in  = count_in + QCNT_W'(push_cnt);
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         count_in  = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_mode_ff <= QUOTE_NONE;
         in_word_ff    <= 1'b0;
         escape_ff     <= 1'b0;
         out_pos_ff    <= '0;
         args_seen_ff  <= '0;
         skipping_ff   <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (req_fire) begin
            quote_mode_ff <= quote_mode_in;
            in_word_ff    <= in_word_in;
            escape_ff     <= escape_in;
            out_pos_ff    <= out_pos_in;
            args_seen_ff  <= args_seen_in;
            skipping_ff   <= skipping_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire && (push_cnt != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res_a;
      end
      if (req_fire && (push_cnt == 2'd2)) begin
         queue_ff[wr_ptr_ff + 1'b1] <= res_b;
      end
   end

   // ---------------------------------------------------------------------
   // Result port
   // ---------------------------------------------------------------------
   result_type head;
   assign head = queue_ff[rd_ptr_ff];

   assign rsp_tdata = {5'b0, head.arg_count, head.status, head.arg_index,
                       head.position, head.write_byte};
   assign rsp_tuser = {head.arg_start, head.write_en};
   assign rsp_tlast = head.done_res;

endmodule
